FILE: rtl/core/l2e_pkg.sv
// Package for the link-layer echo engine: shared constants, codes and payload types.
// No dependencies; every module of the engine but l2e_ram refers to it by scoped names.
`default_nettype none

package l2e_pkg;

   // The timestamp ring holds the send times of the most recent requests.
   // Its depth must be a power of two so that the slot is a mask of the sequence number.
   localparam int unsigned RingDepth  = 64;
   localparam int unsigned RingAw     = $clog2(RingDepth);
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueueAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

   localparam int unsigned HeaderBytes = 32;
   localparam logic [15:0] EtypeEcho   = 16'h4304;
   localparam logic [7:0]  TypeReq     = 8'd128;
   localparam logic [7:0]  TypeRep     = 8'd129;

   localparam logic OpSend    = 1'b0;
   localparam logic OpReceive = 1'b1;

   typedef enum logic [2:0] {
      CSR_OWN_MAC      = 3'd0,
      CSR_LISTEN_MODE  = 3'd1,
      CSR_SESSION_ID   = 3'd2,
      CSR_REPLY_TO_MAC = 3'd3,
      CSR_PAYLOAD_SIZE = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ACT_IGNORED    = 3'd0,
      ACT_MALFORMED  = 3'd1,
      ACT_UNKNOWN    = 3'd2,
      ACT_SEND_REPLY = 3'd3,
      ACT_RTT_VALID  = 3'd4,
      ACT_RTT_NA     = 3'd5,
      ACT_SEND_REQ   = 3'd6
   } action_type;

   typedef struct packed {
      logic        opcode;
      logic [39:0] timestamp_us;
      logic [13:0] frame_len;
      logic [47:0] dest_mac;
      logic [47:0] src_mac;
      logic [15:0] ether_type;
      logic [15:0] rx_paylen;
      logic [7:0]  msg_type;
      logic [15:0] identifier;
      logic [15:0] seqno;
      logic [47:0] reply_to;
   } req_payload_type;

   typedef struct packed {
      action_type  action;
      logic [47:0] out_dest;
      logic [47:0] out_source;
      logic [47:0] out_reply_to;
      logic [7:0]  out_type;
      logic [15:0] out_ident;
      logic [15:0] out_seq;
      logic [15:0] out_paylen;
      logic [39:0] rtt_us;
   } rsp_payload_type;

   // Classified transaction as it leaves the front stage.
   typedef struct packed {
      action_type  action;
      logic [47:0] out_dest;
      logic [47:0] out_source;
      logic [47:0] out_reply_to;
      logic [7:0]  out_type;
      logic [15:0] out_ident;
      logic [15:0] out_seq;
      logic [15:0] out_paylen;
      logic [39:0] now_us;
   } front_item_type;

   // Queue entry: the classified transaction and the send time read from the ring.
   typedef struct packed {
      front_item_type head;
      logic [39:0]    sent_us;
   } queue_item_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/l2e_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module l2e_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/l2e_front.sv
// Front stage: configuration registers, header classification, sequence counter and
// timestamp ring. Depends on l2e_pkg and l2e_ram.
`default_nettype none

module l2e_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [47:0]                 csr_wdata,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire l2e_pkg::req_payload_type    req_payload,
   input  wire l2e_pkg::queue_status_type   q_status,
   output logic                             q_push,
   output l2e_pkg::queue_item_type          q_item
);

   logic [47:0] own_mac_ff, own_mac_in;
   logic        listen_ff, listen_in;
   logic [15:0] session_ff, session_in;
   logic [47:0] reply_to_mac_ff, reply_to_mac_in;
   logic [15:0] pay_size_ff, pay_size_in;
   logic [15:0] send_count_ff, send_count_in;
   logic        f_valid_ff, f_valid_in;
   l2e_pkg::front_item_type f_item_ff, f_item_in;

   logic                       accept;
   logic                       hdr_short;
   logic [13:0]                body_len;
   logic                       len_bad;
   logic                       etype_bad;
   logic [15:0]                win_lo;
   logic                       in_window;
   logic [15:0]                seq_m1;
   logic [15:0]                send_next;
   logic [39:0]                ram_rd_data;

   assign q_push    = f_valid_ff && !q_status.full;
   assign req_ready = !f_valid_ff || !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      own_mac_in      = own_mac_ff;
      listen_in       = listen_ff;
      session_in      = session_ff;
      reply_to_mac_in = reply_to_mac_ff;
      pay_size_in     = pay_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            l2e_pkg::CSR_OWN_MAC:      own_mac_in      = csr_wdata;
            l2e_pkg::CSR_LISTEN_MODE:  listen_in       = csr_wdata[0];
            l2e_pkg::CSR_SESSION_ID:   session_in      = csr_wdata[15:0];
            l2e_pkg::CSR_REPLY_TO_MAC: reply_to_mac_in = csr_wdata;
            l2e_pkg::CSR_PAYLOAD_SIZE: pay_size_in     = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign send_next = send_count_ff + 16'd1;
   assign seq_m1    = req_payload.seqno - 16'd1;
   assign hdr_short = req_payload.frame_len < 14'(l2e_pkg::HeaderBytes);
   assign body_len  = req_payload.frame_len - 14'(l2e_pkg::HeaderBytes);
   assign len_bad   = req_payload.rx_paylen > {2'b00, body_len};
   assign etype_bad = req_payload.ether_type != l2e_pkg::EtypeEcho;
   assign win_lo    = (send_count_ff > 16'(l2e_pkg::RingDepth))
                      ? send_count_ff - 16'(l2e_pkg::RingDepth) + 16'd1 : 16'd1;
   assign in_window = (req_payload.seqno >= win_lo) && (req_payload.seqno <= send_count_ff);

   always_comb begin
      f_item_in        = '0;
      f_item_in.now_us = req_payload.timestamp_us;
      if (req_payload.opcode == l2e_pkg::OpSend) begin
         f_item_in.action       = l2e_pkg::ACT_SEND_REQ;
         f_item_in.out_source   = own_mac_ff;
         f_item_in.out_reply_to = (reply_to_mac_ff != 48'd0) ? reply_to_mac_ff : own_mac_ff;
         f_item_in.out_type     = l2e_pkg::TypeReq;
         f_item_in.out_ident    = session_ff;
         f_item_in.out_seq      = send_next;
         f_item_in.out_paylen   = pay_size_ff;
      end else if (hdr_short || len_bad || etype_bad) begin
         f_item_in.action = l2e_pkg::ACT_MALFORMED;
      end else if ((req_payload.src_mac == own_mac_ff)
                   || ((req_payload.dest_mac != own_mac_ff) && !req_payload.dest_mac[40])) begin
         f_item_in.action = l2e_pkg::ACT_IGNORED;
      end else if (req_payload.msg_type == l2e_pkg::TypeReq) begin
         if (listen_ff) begin
            f_item_in.action       = l2e_pkg::ACT_SEND_REPLY;
            f_item_in.out_dest     = req_payload.reply_to;
            f_item_in.out_source   = own_mac_ff;
            f_item_in.out_reply_to = own_mac_ff;
            f_item_in.out_type     = l2e_pkg::TypeRep;
            f_item_in.out_ident    = req_payload.identifier;
            f_item_in.out_seq      = req_payload.seqno;
            f_item_in.out_paylen   = req_payload.rx_paylen;
         end
      end else if (req_payload.msg_type == l2e_pkg::TypeRep) begin
         if (!listen_ff && (req_payload.identifier == session_ff)) begin
            f_item_in.out_seq = req_payload.seqno;
            f_item_in.action  = in_window ? l2e_pkg::ACT_RTT_VALID : l2e_pkg::ACT_RTT_NA;
         end
      end else begin
         f_item_in.action = l2e_pkg::ACT_UNKNOWN;
      end
   end

   always_comb begin
      send_count_in = send_count_ff;
      if (accept && (req_payload.opcode == l2e_pkg::OpSend)) begin
         send_count_in = send_next;
      end
      f_valid_in = f_valid_ff;
      if (accept) begin
         f_valid_in = 1'b1;
      end else if (q_push) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff      <= '0;
         listen_ff       <= 1'b0;
         session_ff      <= '0;
         reply_to_mac_ff <= '0;
         pay_size_ff     <= '0;
         send_count_ff   <= '0;
         f_valid_ff      <= 1'b0;
      end else begin
         own_mac_ff      <= own_mac_in;
         listen_ff       <= listen_in;
         session_ff      <= session_in;
         reply_to_mac_ff <= reply_to_mac_in;
         pay_size_ff     <= pay_size_in;
         send_count_ff   <= send_count_in;
         f_valid_ff      <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_item_ff <= f_item_in;
      end
   end

   // The read data register holds until the next accepted transaction, which cannot
   // happen before the staged transaction has moved into the queue.
   l2e_ram #(
      .WIDTH (40),
      .DEPTH (l2e_pkg::RingDepth)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept && (req_payload.opcode == l2e_pkg::OpSend)),
      .wr_addr (send_count_ff[l2e_pkg::RingAw-1:0]),
      .wr_data (req_payload.timestamp_us),
      .rd_en   (accept && (req_payload.opcode == l2e_pkg::OpReceive)),
      .rd_addr (seq_m1[l2e_pkg::RingAw-1:0]),
      .rd_data (ram_rd_data)
   );

   assign q_item.head    = f_item_ff;
   assign q_item.sent_us = ram_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/l2e_queue.sv
// Short queue between the front and back stages.
// Depends on l2e_pkg.
`default_nettype none

module l2e_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire l2e_pkg::queue_ctrl_type     ctrl,
   input  wire l2e_pkg::queue_item_type     wr_item,
   output l2e_pkg::queue_status_type        status,
   output l2e_pkg::queue_item_type          rd_item
);

   l2e_pkg::queue_item_type entry_ff [l2e_pkg::QueueDepth];
   logic [l2e_pkg::QueueAw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [l2e_pkg::QueueAw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [l2e_pkg::QueueCw-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign status.full  = count_ff == l2e_pkg::QueueCw'(l2e_pkg::QueueDepth);
   assign status.empty = count_ff == '0;
   assign do_push      = ctrl.push && !status.full;
   assign do_pop       = ctrl.pop && !status.empty;
   assign rd_item      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == l2e_pkg::QueueAw'(l2e_pkg::QueueDepth - 1))
                     ? '0 : wr_ptr_ff + l2e_pkg::QueueAw'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == l2e_pkg::QueueAw'(l2e_pkg::QueueDepth - 1))
                     ? '0 : rd_ptr_ff + l2e_pkg::QueueAw'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + l2e_pkg::QueueCw'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - l2e_pkg::QueueCw'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/l2e_back.sv
// Back stage: computes the round trip and holds the result in the output register.
// Depends on l2e_pkg.
`default_nettype none

module l2e_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire l2e_pkg::queue_status_type   q_status,
   input  wire l2e_pkg::queue_item_type     q_item,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output l2e_pkg::rsp_payload_type         rsp_payload
);

   logic                     out_valid_ff, out_valid_in;
   l2e_pkg::rsp_payload_type rsp_ff, rsp_in;

   assign q_pop = !q_status.empty && (!out_valid_ff || rsp_ready);

   always_comb begin
      rsp_in.action       = q_item.head.action;
      rsp_in.out_dest     = q_item.head.out_dest;
      rsp_in.out_source   = q_item.head.out_source;
      rsp_in.out_reply_to = q_item.head.out_reply_to;
      rsp_in.out_type     = q_item.head.out_type;
      rsp_in.out_ident    = q_item.head.out_ident;
      rsp_in.out_seq      = q_item.head.out_seq;
      rsp_in.out_paylen   = q_item.head.out_paylen;
      rsp_in.rtt_us       = '0;
      // A send time later than the reply clamps the round trip at zero.
      if ((q_item.head.action == l2e_pkg::ACT_RTT_VALID)
          && (q_item.head.now_us > q_item.sent_us)) begin
         rsp_in.rtt_us = q_item.head.now_us - q_item.sent_us;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/layer2_echo_engine_core.sv
// Top level of the link-layer echo engine: front stage, queue and back stage.
// Depends on l2e_pkg, l2e_front, l2e_queue and l2e_back.
//
//   Channel  Ports                             Direction  Moves
//   req      req_valid/req_ready/req_payload   in         one event transaction
//   rsp      rsp_valid/rsp_ready/rsp_payload   out        one result transaction
//   csr      csr_we/csr_index/csr_wdata        in         register write, no wait
//
// One transaction per cycle is sustained while rsp_ready is high; a result passes through
// the front register, a queue entry and the output register, in that order.
// The ring read is issued when a transaction is accepted, so it is ordered with sends.
// Reset is synchronous and clears configuration, the sequence counter and all valids.
// A stalled rsp side fills the output register, the two-entry queue and the front register
// before req stalls.
`default_nettype none

module layer2_echo_engine_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [47:0]                csr_wdata,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire l2e_pkg::req_payload_type   req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output l2e_pkg::rsp_payload_type        rsp_payload
);

   l2e_pkg::queue_ctrl_type   q_ctrl;
   l2e_pkg::queue_status_type q_status;
   l2e_pkg::queue_item_type   q_wr_item;
   l2e_pkg::queue_item_type   q_rd_item;
   logic                      q_push;
   logic                      q_pop;

   assign q_ctrl = '{push: q_push, pop: q_pop};

   l2e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_item      (q_wr_item)
   );

   l2e_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (q_ctrl),
      .wr_item (q_wr_item),
      .status  (q_status),
      .rd_item (q_rd_item)
   );

   l2e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_item      (q_rd_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: test/l2e_echo_checker.sv
// Checker for the link-layer echo engine: follows register writes, predicts each result
// from accepted event transactions and compares the result transactions in order.
// Depends on l2e_pkg for the payload types, codes and ring depth.
module l2e_echo_checker
   import l2e_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic [2:0]      csr_index,
   input  wire logic [47:0]     csr_wdata,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire rsp_payload_type rsp_payload,
   output int                   failures,
   output int                   pending
);

   localparam int Hdr = int'(HeaderBytes);

   logic [47:0] own_addr;
   logic        listening;
   logic [15:0] session;
   logic [47:0] reply_addr;
   logic [15:0] req_paylen;

   logic [15:0] seq_count;
   logic [39:0] stamp_ring [RingDepth];

   rsp_payload_type expected_results [$];
   int              mismatch_total;

   function automatic int ring_slot(input logic [15:0] s);
      logic [15:0] p;
      p = s - 16'd1;
      return int'(p % 16'(RingDepth));
   endfunction

   function automatic rsp_payload_type echo_outcome(input req_payload_type ev);
      rsp_payload_type r;
      logic [15:0]     lo;
      logic [39:0]     sent;
      int              flen;
      int              plen;
      r = '0;
      flen = int'(ev.frame_len);
      plen = int'(ev.rx_paylen);
      if (ev.opcode == OpSend) begin
         seq_count = seq_count + 16'd1;
         stamp_ring[ring_slot(seq_count)] = ev.timestamp_us;
         r.action       = ACT_SEND_REQ;
         r.out_source   = own_addr;
         r.out_reply_to = (reply_addr != 48'd0) ? reply_addr : own_addr;
         r.out_type     = TypeReq;
         r.out_ident    = session;
         r.out_seq      = seq_count;
         r.out_paylen   = req_paylen;
      end else if (flen < Hdr || plen > flen - Hdr || ev.ether_type != EtypeEcho) begin
         r.action = ACT_MALFORMED;
      end else if (ev.src_mac == own_addr || (ev.dest_mac != own_addr && !ev.dest_mac[40])) begin
         r.action = ACT_IGNORED;
      end else if (ev.msg_type == TypeReq) begin
         if (listening) begin
            r.action       = ACT_SEND_REPLY;
            r.out_dest     = ev.reply_to;
            r.out_source   = own_addr;
            r.out_reply_to = own_addr;
            r.out_type     = TypeRep;
            r.out_ident    = ev.identifier;
            r.out_seq      = ev.seqno;
            r.out_paylen   = ev.rx_paylen;
         end
      end else if (ev.msg_type == TypeRep) begin
         if (!listening && ev.identifier == session) begin
            // The window does not wrap: after the counter wraps only the new pass counts.
            lo = (seq_count > 16'(RingDepth)) ? 16'(seq_count - 16'(RingDepth) + 16'd1)
                                              : 16'd1;
            r.out_seq = ev.seqno;
            if (ev.seqno >= lo && ev.seqno <= seq_count) begin
               sent = stamp_ring[ring_slot(ev.seqno)];
               r.action = ACT_RTT_VALID;
               r.rtt_us = (ev.timestamp_us > sent) ? ev.timestamp_us - sent : 40'd0;
            end else begin
               r.action = ACT_RTT_NA;
            end
         end
      end else begin
         r.action = ACT_UNKNOWN;
      end
      return r;
   endfunction

   task automatic show_result(input string tag, input rsp_payload_type r);
      $display("   %s: action %0d dest %h source %h reply_to %h type %h", tag, r.action,
               r.out_dest, r.out_source, r.out_reply_to, r.out_type);
      $display("   %s: ident %h seq %h paylen %h rtt %h", tag, r.out_ident, r.out_seq,
               r.out_paylen, r.rtt_us);
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      logic            bad;
      if (reset) begin
         own_addr   = '0;
         listening  = 1'b0;
         session    = '0;
         reply_addr = '0;
         req_paylen = '0;
         seq_count  = '0;
         expected_results.delete();
         mismatch_total = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_MAC:      own_addr   = csr_wdata;
               CSR_LISTEN_MODE:  listening  = csr_wdata[0];
               CSR_SESSION_ID:   session    = csr_wdata[15:0];
               CSR_REPLY_TO_MAC: reply_addr = csr_wdata;
               CSR_PAYLOAD_SIZE: req_paylen = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10) begin
                  $display("ERROR: result transaction with nothing expected");
                  show_result("actual", rsp_payload);
               end
            end else begin
               want = expected_results.pop_front();
               bad = (rsp_payload.action !== want.action)
                  || (rsp_payload.out_dest !== want.out_dest)
                  || (rsp_payload.out_source !== want.out_source)
                  || (rsp_payload.out_reply_to !== want.out_reply_to)
                  || (rsp_payload.out_type !== want.out_type)
                  || (rsp_payload.out_ident !== want.out_ident)
                  || (rsp_payload.out_seq !== want.out_seq)
                  || (rsp_payload.out_paylen !== want.out_paylen)
                  || (rsp_payload.rtt_us !== want.rtt_us);
               if (bad) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("ERROR: result transaction mismatch");
                     show_result("expected", want);
                     show_result("actual", rsp_payload);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(echo_outcome(req_payload));
         end
      end
      failures <= mismatch_total;
      pending <= expected_results.size();
   end

endmodule

FILE: test/tb_layer2_echo_engine_core.sv
// Testbench top for the link-layer echo engine: clock, reset, register settings and
// event stimulus under varied idling; depends on l2e_pkg, the engine and l2e_echo_checker.
module tb_layer2_echo_engine_core;
   import l2e_pkg::*;

   localparam int          StallLimit  = 5000;
   localparam int          RandomItems = 75;
   localparam logic [47:0] OwnA  = 48'h02_11_22_33_44_55;
   localparam logic [47:0] PeerB = 48'h02_AA_BB_CC_DD_EE;
   localparam logic [47:0] PeerC = 48'h04_01_02_03_04_05;
   localparam logic [47:0] Group = 48'h01_00_5E_00_00_01;

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_we;
   logic [2:0]      csr_index;
   logic [47:0]     csr_wdata;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   int          failures;
   int          pending;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          quiet_cycles = 0;
   logic [15:0] sends_issued = '0;
   logic [39:0] now_us = '0;
   logic [47:0] cfg_own;
   logic [15:0] cfg_session;

   always #1 clock = ~clock;

   layer2_echo_engine_core uut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   l2e_echo_checker u_echo_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .failures    (failures),
      .pending     (pending)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [47:0] rand48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0];
   endfunction

   function automatic logic [39:0] rand40();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[39:0];
   endfunction

   function automatic req_payload_type noise_item();
      req_payload_type ev;
      ev.opcode       = 1'($urandom_range(1));
      ev.timestamp_us = rand40();
      ev.frame_len    = 14'($urandom_range(16383));
      ev.dest_mac     = rand48();
      ev.src_mac      = rand48();
      ev.ether_type   = ($urandom_range(3) == 0) ? EtypeEcho : 16'($urandom_range(65535));
      ev.rx_paylen    = 16'($urandom_range(65535));
      ev.msg_type     = 8'($urandom_range(255));
      ev.identifier   = 16'($urandom_range(65535));
      ev.seqno        = 16'($urandom_range(65535));
      ev.reply_to     = rand48();
      return ev;
   endfunction

   function automatic req_payload_type send_round(input logic [39:0] ts);
      req_payload_type ev;
      ev = noise_item();
      ev.opcode = OpSend;
      ev.timestamp_us = ts;
      return ev;
   endfunction

   function automatic req_payload_type header(input logic [47:0] dst, input logic [47:0] src,
                                              input logic [7:0] mtype, input logic [15:0] ident,
                                              input logic [15:0] seq);
      req_payload_type ev;
      ev = noise_item();
      ev.opcode       = OpReceive;
      ev.timestamp_us = now_us;
      ev.frame_len    = 14'(HeaderBytes);
      ev.rx_paylen    = '0;
      ev.ether_type   = EtypeEcho;
      ev.dest_mac     = dst;
      ev.src_mac      = src;
      ev.msg_type     = mtype;
      ev.identifier   = ident;
      ev.seqno        = seq;
      return ev;
   endfunction

   // Sends and mostly well-formed traffic aimed at the current addresses, session and
   // the edge of the sequence window, plus broken headers and pure noise.
   function automatic req_payload_type random_event();
      req_payload_type ev;
      int              pick;
      int              room;
      logic [47:0]     dst;
      logic [7:0]      mtype;
      now_us = now_us + 40'($urandom_range(2000));
      if ($urandom_range(49) == 0) now_us = rand40();
      pick = $urandom_range(99);
      if (pick < 12) return noise_item();
      if (pick < 42) return send_round(now_us);
      pick = $urandom_range(99);
      dst = (pick < 60) ? cfg_own : (pick < 90) ? (rand48() | 48'h01_00_00_00_00_00)
                                               : (rand48() & ~48'h01_00_00_00_00_00);
      pick = $urandom_range(99);
      mtype = (pick < 45) ? TypeReq : (pick < 90) ? TypeRep : 8'($urandom_range(255));
      ev = header(dst, ($urandom_range(32) == 0) ? cfg_own : rand48(), mtype,
                  ($urandom_range(6) == 0) ? 16'($urandom_range(65535)) : cfg_session,
                  ($urandom_range(9) < 7) ? 16'(sends_issued - 16'($urandom_range(70)))
                                          : 16'($urandom_range(65535)));
      if ($urandom_range(3) != 0) ev.frame_len = 14'($urandom_range(HeaderBytes, 16383));
      room = int'(ev.frame_len) - int'(HeaderBytes);
      ev.rx_paylen = 16'($urandom_range(room));
      pick = $urandom_range(99);
      if (pick < 4) ev.rx_paylen = 16'(room + 1);
      else if (pick < 7) ev.frame_len = 14'($urandom_range(HeaderBytes - 1));
      else if (pick < 10) ev.ether_type = 16'($urandom_range(65535));
      return ev;
   endfunction

   task automatic push_event(input req_payload_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= ev;
      if (ev.opcode == OpSend) sends_issued = sends_issued + 16'd1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [47:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [47:0] own, input logic listen,
                            input logic [15:0] sess, input logic [47:0] rto,
                            input logic [15:0] psize);
      write_reg(CSR_OWN_MAC, own);
      write_reg(CSR_LISTEN_MODE, {47'd0, listen});
      write_reg(CSR_SESSION_ID, {32'd0, sess});
      write_reg(CSR_REPLY_TO_MAC, rto);
      write_reg(CSR_PAYLOAD_SIZE, {32'd0, psize});
      csr_we <= 1'b0;
      cfg_own = own;
      cfg_session = sess;
   endtask

   initial begin : stimulus
      req_payload_type ev;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Measuring side: window edges, clamped round trip and every header check.
      configure(OwnA, 1'b0, 16'h1234, 48'd0, 16'd100);
      push_event(send_round(40'd0));
      push_event(send_round(40'hFF_FFFF_FFFF));
      ev = header(OwnA, PeerB, TypeRep, 16'h1234, 16'd1);
      ev.timestamp_us = 40'd100;
      push_event(ev);
      ev = header(OwnA, PeerB, TypeRep, 16'h1234, 16'd2);
      ev.timestamp_us = 40'd5;
      push_event(ev);
      push_event(header(OwnA, PeerB, TypeRep, 16'h1234, 16'd3));
      push_event(header(OwnA, PeerB, TypeRep, 16'h1234, 16'd0));
      push_event(header(OwnA, PeerB, TypeRep, 16'h1234, 16'hFFFF));
      push_event(header(OwnA, PeerB, TypeRep, 16'h1235, 16'd1));
      push_event(header(OwnA, PeerB, TypeReq, 16'h1234, 16'd1));
      ev = header(OwnA, PeerB, TypeRep, 16'h1234, 16'd1);
      ev.frame_len = 14'd31;
      push_event(ev);
      ev.frame_len = 14'd100;
      ev.rx_paylen = 16'd69;
      push_event(ev);
      ev.rx_paylen = 16'd68;
      ev.msg_type = 8'hFF;
      push_event(ev);
      ev = header(OwnA, PeerB, TypeRep, 16'h1234, 16'd1);
      ev.ether_type = 16'h4305;
      push_event(ev);
      push_event(header(OwnA, OwnA, TypeRep, 16'h1234, 16'd1));
      push_event(header(PeerC, PeerB, TypeRep, 16'h1234, 16'd1));
      push_event(header(Group, PeerB, TypeRep, 16'h1234, 16'd1));
      ev = header(OwnA, PeerB, TypeRep, 16'h1234, 16'd1);
      ev.frame_len = 14'h3FFF;
      ev.rx_paylen = 16'hFFFF;
      push_event(ev);
      settle_idle();

      // Answering side: explicit reply-to address and full-range reply fields.
      configure(OwnA, 1'b1, 16'h1234, PeerB, 16'hFFFF);
      push_event(send_round(40'd7));
      ev = header(OwnA, PeerB, TypeReq, 16'hFFFF, 16'hFFFF);
      ev.reply_to = '1;
      ev.frame_len = 14'h3FFF;
      ev.rx_paylen = 16'(16383 - HeaderBytes);
      push_event(ev);
      push_event(header(OwnA, PeerB, TypeRep, 16'h1234, 16'd1));
      push_event(header(Group, PeerB, 8'd0, 16'h1234, 16'd1));

      for (int p = 0; p < 6; p++) begin
         settle_idle();
         case (p)
            0: configure(OwnA, 1'b0, 16'hBEEF, 48'd0, 16'd1500);
            1: configure(OwnA, 1'b1, 16'h0000, '1, 16'hFFFF);
            2: configure('1, 1'b0, 16'hFFFF, 48'd0, 16'h0000);
            3: configure(48'd0, 1'b1, 16'h0000, rand48(), 16'h0000);
            4: configure(rand48() & ~48'h01_00_00_00_00_00, 1'b0, 16'($urandom_range(65535)),
                         rand48(), 16'($urandom_range(65535)));
            default: configure(rand48(), 1'($urandom_range(1)), 16'($urandom_range(65535)),
                               rand48(), 16'($urandom_range(65535)));
         endcase
         send_idle_pct = (p == 1 || p == 3 || p == 4) ? ((p == 1) ? 72 : 17) : 0;
         rsp_stall_pct = (p == 2 || p == 5) ? 72 : (p == 3 || p == 4) ? 17 : 0;
         for (int i = 0; i < RandomItems; i++) begin
            push_event(random_event());
            if (i == RandomItems / 2 && p == 1) settle_idle();
         end
      end

      settle_idle();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: layer2_echo_engine_core.f
rtl/core/l2e_pkg.sv
rtl/core/l2e_ram.sv
rtl/core/l2e_front.sv
rtl/core/l2e_queue.sv
rtl/core/l2e_back.sv
rtl/core/layer2_echo_engine_core.sv
test/l2e_echo_checker.sv
test/tb_layer2_echo_engine_core.sv
